FILE: sv/assert_macros.svh
// assertion macros used by wgss_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define ASSERT_IMPLY(lbl, clk, rstn, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, cond, expr, msg)

`endif

`endif

FILE: sv/wgss_pkg.sv
`default_nettype none

package wgss_pkg;

    // sample, product and accumulator widths
    localparam int SW  = 24;
    localparam int PW  = 43;
    localparam int ACW = 45;

    localparam logic signed [SW-1:0] SAT_MAX = 24'sh7fffff;
    localparam logic signed [SW-1:0] SAT_MIN = 24'sh800000;

    // configuration register indexes
    localparam logic [2:0] CFG_DELAY_LENGTH = 3'd0;
    localparam logic [2:0] CFG_TAP_OFFSET   = 3'd1;
    localparam logic [2:0] CFG_TUNING_COEF  = 3'd2;
    localparam logic [2:0] CFG_DAMPING_B0   = 3'd3;
    localparam logic [2:0] CFG_DAMPING_B1   = 3'd4;

    // request opcodes
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_EXCITE = 1'b1;

    // shared multiplier operand selection
    typedef logic [1:0] t_mul_sel;
    localparam t_mul_sel MUL_UP = 2'd0;
    localparam t_mul_sel MUL_LO = 2'd1;
    localparam t_mul_sel MUL_B0 = 2'd2;
    localparam t_mul_sel MUL_B1 = 2'd3;

    typedef struct packed {
        logic     clr_wr;
        logic     accept;
        logic     rd_tick_taps;
        logic     rd_exc_taps;
        logic     rd_pos;
        logic     cap_sample;
        logic     cap_x;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     fin_up;
        logic     fin_lo;
        logic     hold_acc;
        logic     fin_damp;
        logic     wr_excite;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: sv/wgss_datapath.sv
`default_nettype none

module wgss_datapath import wgss_pkg::*; #(
    parameter int LINE_DEPTH = 512
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [17:0]          i_cfg_data,
    input  wire logic signed [SW-1:0] i_excite_value,
    output logic signed [SW-1:0]      o_sample
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int LW = AW + 1;
    localparam int CW = (LW > 10) ? LW : 10;

    localparam logic signed [SW:0] SMAX25 = 25'sd8388607;
    localparam logic signed [SW:0] SMIN25 = -25'sd8388608;
    localparam logic signed [28:0] SMAX29 = 29'sd8388607;
    localparam logic signed [28:0] SMIN29 = -29'sd8388608;

    // saturate a 25 bit sum to a sample
    function automatic logic signed [SW-1:0] f_sat25(input logic signed [SW:0] v);
        logic signed [SW-1:0] r;
        if (v > SMAX25) begin
            r = SAT_MAX;
        end else if (v < SMIN25) begin
            r = SAT_MIN;
        end else begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    // round half up from q29.16 to an integer sample, then saturate
    function automatic logic signed [SW-1:0] f_round(input logic signed [ACW-1:0] acc);
        logic signed [ACW-1:0] t;
        logic signed [28:0]    q;
        logic signed [SW-1:0]  r;
        t = acc + 45'sd32768;
        q = t[ACW-1:16];
        if (q > SMAX29) begin
            r = SAT_MAX;
        end else if (q < SMIN29) begin
            r = SAT_MIN;
        end else begin
            r = q[SW-1:0];
        end
        return r;
    endfunction

    // configuration registers
    logic [9:0]         r_len_cfg;
    logic [8:0]         r_off_cfg;
    logic signed [15:0] r_coef;
    logic signed [17:0] r_b0;
    logic signed [17:0] r_b1;

    // control-side state
    logic [AW-1:0]        r_pos;
    logic [AW-1:0]        r_clr_addr;
    logic signed [SW-1:0] r_uap_in;
    logic signed [SW-1:0] r_uap_out;
    logic signed [SW-1:0] r_lap_in;
    logic signed [SW-1:0] r_lap_out;
    logic signed [SW-1:0] r_dprev;

    // working registers
    logic signed [SW-1:0] r_exc;
    logic signed [SW-1:0] r_sample;
    logic signed [SW-1:0] r_out;
    logic signed [SW-1:0] r_ux;
    logic signed [SW-1:0] r_lx;
    logic signed [SW-1:0] r_pu;
    logic signed [SW-1:0] r_u;
    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] r_acc0;

    // delay line memories
    logic [SW-1:0] r_mem_u [LINE_DEPTH];
    logic [SW-1:0] r_mem_l [LINE_DEPTH];
    logic signed [SW-1:0] r_rd_u;
    logic signed [SW-1:0] r_rd_l;

    logic [CW-1:0] len_w;
    logic [CW-1:0] off_w;
    logic [LW-1:0] len;
    logic [AW-1:0] off;
    logic [AW-1:0] p_eff;
    logic [LW-1:0] fwd_s;
    logic [LW-1:0] back_s;
    logic [LW-1:0] pn_s;
    logic [AW-1:0] fwd;
    logic [AW-1:0] back;
    logic [AW-1:0] p_next;

    // effective length, offset and tap addresses
    always_comb begin
        len_w = CW'(r_len_cfg);
        if (len_w < CW'(2)) begin
            len_w = CW'(2);
        end else if (len_w > CW'(LINE_DEPTH)) begin
            len_w = CW'(LINE_DEPTH);
        end
        len   = LW'(len_w);
        off_w = CW'(r_off_cfg);
        if (off_w >= CW'(len)) begin
            off_w = CW'(len) - CW'(1);
        end
        off    = AW'(off_w);
        p_eff  = (LW'(r_pos) >= len) ? '0 : r_pos;
        fwd_s  = LW'(p_eff) + LW'(off);
        back_s = LW'(p_eff) + (len - LW'(off));
        pn_s   = LW'(p_eff) + LW'(1);
        fwd    = (fwd_s >= len) ? AW'(fwd_s - len) : AW'(fwd_s);
        back   = (back_s >= len) ? AW'(back_s - len) : AW'(back_s);
        p_next = (pn_s >= len) ? '0 : AW'(pn_s);
    end

    // shared multiplier operands
    logic signed [SW:0] ma;
    logic signed [17:0] mb;

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_UP: begin
                ma = {r_rd_u[SW-1], r_rd_u} - {r_uap_out[SW-1], r_uap_out};
                mb = {{2{r_coef[15]}}, r_coef};
            end
            MUL_LO: begin
                ma = {r_lx[SW-1], r_lx} - {r_lap_out[SW-1], r_lap_out};
                mb = {{2{r_coef[15]}}, r_coef};
            end
            MUL_B0: begin
                ma = {r_u[SW-1], r_u};
                mb = r_b0;
            end
            default: begin
                ma = {r_dprev[SW-1], r_dprev};
                mb = r_b1;
            end
        endcase
    end

    // filter accumulators
    logic signed [ACW-1:0] acc_up;
    logic signed [ACW-1:0] acc_lo;
    logic signed [ACW-1:0] acc_dm;
    logic signed [SW-1:0]  pu;
    logic signed [SW-1:0]  yl;
    logic signed [SW-1:0]  d;
    logic signed [SW-1:0]  neg_pu;
    logic signed [SW-1:0]  neg_yl;
    logic signed [SW-1:0]  sum_tap;
    logic signed [SW-1:0]  exc_u;
    logic signed [SW-1:0]  exc_l;

    always_comb begin
        acc_up  = {{2{r_prod[PW-1]}}, r_prod} + {{5{r_uap_in[SW-1]}}, r_uap_in, 16'h0000};
        acc_lo  = {{2{r_prod[PW-1]}}, r_prod} + {{5{r_lap_in[SW-1]}}, r_lap_in, 16'h0000};
        acc_dm  = {{2{r_acc0[PW-1]}}, r_acc0} + {{2{r_prod[PW-1]}}, r_prod};
        pu      = f_round(acc_up);
        yl      = f_round(acc_lo);
        d       = f_round(acc_dm);
        neg_pu  = f_sat25(25'sd0 - {r_pu[SW-1], r_pu});
        neg_yl  = f_sat25(25'sd0 - {yl[SW-1], yl});
        sum_tap = f_sat25({r_rd_u[SW-1], r_rd_u} + {r_rd_l[SW-1], r_rd_l});
        exc_u   = f_sat25({r_rd_u[SW-1], r_rd_u} + {r_exc[SW-1], r_exc});
        exc_l   = f_sat25({r_rd_l[SW-1], r_rd_l} + {r_exc[SW-1], r_exc});
    end

    // memory port selection
    logic          we;
    logic          re;
    logic [AW-1:0] wa_u;
    logic [AW-1:0] wa_l;
    logic [SW-1:0] wd_u;
    logic [SW-1:0] wd_l;
    logic [AW-1:0] ra_u;
    logic [AW-1:0] ra_l;

    always_comb begin
        we = i_cmd.clr_wr | i_cmd.fin_damp | i_cmd.wr_excite;
        re = i_cmd.rd_tick_taps | i_cmd.rd_exc_taps | i_cmd.rd_pos;
        priority if (i_cmd.clr_wr) begin
            wa_u = r_clr_addr;
            wa_l = r_clr_addr;
            wd_u = '0;
            wd_l = '0;
        end else if (i_cmd.fin_damp) begin
            wa_u = p_eff;
            wa_l = p_eff;
            wd_u = d;
            wd_l = neg_pu;
        end else begin
            wa_u = fwd;
            wa_l = back;
            wd_u = exc_u;
            wd_l = exc_l;
        end
        priority if (i_cmd.rd_tick_taps) begin
            ra_u = back;
            ra_l = fwd;
        end else if (i_cmd.rd_exc_taps) begin
            ra_u = fwd;
            ra_l = back;
        end else begin
            ra_u = p_eff;
            ra_l = p_eff;
        end
    end

    // upper line memory
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem_u[wa_u] <= wd_u;
        end
        if (re) begin
            r_rd_u <= r_mem_u[ra_u];
        end
    end

    // lower line memory
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem_l[wa_l] <= wd_l;
        end
        if (re) begin
            r_rd_l <= r_mem_l[ra_l];
        end
    end

    // configuration, position and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg  <= 10'd512;
            r_off_cfg  <= '0;
            r_coef     <= '0;
            r_b0       <= 18'sd32768;
            r_b1       <= 18'sd32768;
            r_pos      <= '0;
            r_clr_addr <= '0;
            r_uap_in   <= '0;
            r_uap_out  <= '0;
            r_lap_in   <= '0;
            r_lap_out  <= '0;
            r_dprev    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DELAY_LENGTH: r_len_cfg <= i_cfg_data[9:0];
                    CFG_TAP_OFFSET:   r_off_cfg <= i_cfg_data[8:0];
                    CFG_TUNING_COEF:  r_coef    <= i_cfg_data[15:0];
                    CFG_DAMPING_B0:   r_b0      <= i_cfg_data;
                    CFG_DAMPING_B1:   r_b1      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.accept) begin
                r_pos <= p_eff;
            end
            if (i_cmd.fin_lo) begin
                r_lap_in  <= r_lx;
                r_lap_out <= yl;
            end
            if (i_cmd.fin_damp) begin
                r_dprev   <= r_u;
                r_uap_in  <= r_ux;
                r_uap_out <= r_pu;
                r_pos     <= p_next;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_exc <= i_excite_value;
        end
        if (i_cmd.cap_sample) begin
            r_sample <= sum_tap;
        end
        if (i_cmd.cap_x) begin
            r_ux <= r_rd_u;
            r_lx <= r_rd_l;
        end
        if (i_cmd.mul_en) begin
            r_prod <= ma * mb;
        end
        if (i_cmd.fin_up) begin
            r_pu <= pu;
        end
        if (i_cmd.fin_lo) begin
            r_u <= neg_yl;
        end
        if (i_cmd.hold_acc) begin
            r_acc0 <= r_prod;
        end
        if (i_cmd.out_load) begin
            r_out <= r_sample;
        end
    end

    assign o_stat.clr_last = (r_clr_addr == AW'(LINE_DEPTH - 1));
    assign o_sample        = r_out;

endmodule

`default_nettype wire

FILE: sv/wgss_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module wgss_ctrl import wgss_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire logic     i_opcode,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_T1    = 4'd2;
    localparam logic [3:0] S_T2    = 4'd3;
    localparam logic [3:0] S_M2    = 4'd4;
    localparam logic [3:0] S_M3    = 4'd5;
    localparam logic [3:0] S_M4    = 4'd6;
    localparam logic [3:0] S_M5    = 4'd7;
    localparam logic [3:0] S_M6    = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_E1    = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_acc;
    logic       out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    assign out_free   = ~r_out_valid | i_out_ready;

    // sequencer and datapath commands
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.accept = 1'b1;
                    if (i_opcode == OP_EXCITE) begin
                        o_cmd.rd_exc_taps = 1'b1;
                        n_state           = S_E1;
                    end else begin
                        o_cmd.rd_tick_taps = 1'b1;
                        n_state            = S_T1;
                    end
                end
            end
            S_T1: begin
                o_cmd.cap_sample = 1'b1;
                o_cmd.rd_pos     = 1'b1;
                n_state          = S_T2;
            end
            S_T2: begin
                o_cmd.cap_x   = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_UP;
                n_state       = S_M2;
            end
            S_M2: begin
                o_cmd.fin_up  = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_LO;
                n_state       = S_M3;
            end
            S_M3: begin
                o_cmd.fin_lo = 1'b1;
                n_state      = S_M4;
            end
            S_M4: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_B0;
                n_state       = S_M5;
            end
            S_M5: begin
                o_cmd.hold_acc = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_B1;
                n_state        = S_M6;
            end
            S_M6: begin
                o_cmd.fin_damp = 1'b1;
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_E1: begin
                o_cmd.wr_excite = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // a waiting result is never overwritten
    `ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load, out_free, "result overwritten")
    // result is loaded only at the end of a tick
    `ASSERT_IMPLY(a_load_state, i_clk, i_rst_n, o_cmd.out_load,
        (r_state == S_M6) || (r_state == S_OUT), "result loaded outside tick end")
    // clearing pass runs until the last entry
    `ASSERT_CLK(a_clear_hold, i_clk, i_rst_n,
        (r_state == S_CLEAR && !i_stat.clr_last) |=> (r_state == S_CLEAR), "clear cut short")
    // at most one of clr_wr, accept, cap_x, fin_up, fin_lo, hold_acc, fin_damp and wr_excite per cycle
    `ASSERT_CLK(a_one_action, i_clk, i_rst_n,
        $onehot0({o_cmd.clr_wr, o_cmd.accept, o_cmd.cap_x, o_cmd.fin_up, o_cmd.fin_lo,
        o_cmd.hold_acc, o_cmd.fin_damp, o_cmd.wr_excite}), "overlapping datapath actions")

endmodule

`default_nettype wire

FILE: sv/waveguide_string_synth.sv
// tick request: T1, T2, M2-M6 follow accept; result loaded in M6 or OUT, then next request taken
// excite request: taps read on accept and written back in E1, no result
// a finished result waits in an output register while the next request is taken
// reset: synchronous active low; configuration returns to its defaults and filter state to zero
// after reset both delay lines are cleared one entry a cycle, all LINE_DEPTH entries, before any request
`default_nettype none

module waveguide_string_synth import wgss_pkg::*; #(
    parameter int LINE_DEPTH = 512
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_opcode,
    input  wire logic signed [SW-1:0] i_excite_value,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic signed [SW-1:0]      o_sample,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [17:0]          i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    wgss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    wgss_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_excite_value (i_excite_value),
        .o_sample       (o_sample)
    );

endmodule

`default_nettype wire
